// ----- hdl/bet_pkg.sv -----
// Package for the Bezier easing table block: widths, constants, state codes.
// Used by bet_curve and bezier_easing_table.
package bet_pkg;
  localparam int TABLE_STEPS_DEF = 16;
  localparam int MAX_SOLVE_STEPS_DEF = 32;
  localparam int QW = 22;
  localparam int PW = 17;
  localparam logic [23:0] Q_ONE = 24'd4194304;
  localparam logic [16:0] OUT_ONE = 17'd65536;
  localparam logic [23:0] SOLVE_EPS = 24'd419;

  typedef enum logic [1:0] {
    REG_X1 = 2'd0,
    REG_Y1 = 2'd1,
    REG_X2 = 2'd2,
    REG_Y2 = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EV_RD, ST_EV_WAIT, ST_EV_MUL, ST_EV_SUM, ST_OUT,
    ST_RB_EDGE, ST_RB_EVAL, ST_RB_STEP, ST_RB_Y, ST_RB_WR
  } state_t;

  typedef struct packed {
    logic        start;
    logic [23:0] t;
    logic [23:0] c1;
    logic [23:0] c2;
  } curve_req_t;

  // coefficient round(v*3*ONE/127); divide by 127 as multiply by
  // ceil(2^38/127) and shift, exact for num below 2^31
  function automatic logic [23:0] coef_of(input logic [6:0] v);
    logic [31:0] num;
    logic [63:0] prod;
    num = 32'(v) * 32'd12582912 + 32'd63;
    prod = 64'(num) * 64'd2164392969;
    return 24'(prod >> 38);
  endfunction
endpackage

// ----- hdl/bet_if.sv -----
// Valid/ready channel interface for the easing table.
// Depends on nothing; payload width is a parameter.
interface bet_if #(parameter int W = 18) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/bet_ram.sv -----
// Generic single-port write, one-port read RAM with registered read.
// No dependencies.
module bet_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 17
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/bet_curve.sv -----
// Pipelined curve evaluator: (1-t)^2*t*c1 + (1-t)*t^2*c2 + t^3, Q2.22 in, Q4.22 out.
// Uses bet_pkg. Result and done leave the input, square, cube and coefficient registers together.
module bet_curve (
  input  logic clk,
  input  logic rst,
  input  bet_pkg::curve_req_t req,
  output logic done,
  output logic [25:0] value
);
  import bet_pkg::*;
  logic [3:0] vld;
  logic [23:0] t1, s1, c1a, c2a;
  logic [23:0] ss, tt, t2, s2, c1b, c2b;
  logic [23:0] sst, stt, ttt, c1c, c2c;
  logic [23:0] a, b, ttt2;
  logic [47:0] p_ss, p_tt, p_sst, p_stt, p_ttt, p_a, p_b;

  assign p_ss = 48'(s1) * 48'(s1);
  assign p_tt = 48'(t1) * 48'(t1);
  assign p_sst = 48'(ss) * 48'(t2);
  assign p_stt = 48'(s2) * 48'(tt);
  assign p_ttt = 48'(tt) * 48'(t2);
  assign p_a = 48'(sst) * 48'(c1c);
  assign p_b = 48'(stt) * 48'(c2c);

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[2:0], req.start};
    t1 <= req.t; s1 <= Q_ONE - req.t; c1a <= req.c1; c2a <= req.c2;
    ss <= 24'(p_ss >> QW); tt <= 24'(p_tt >> QW);
    t2 <= t1; s2 <= s1; c1b <= c1a; c2b <= c2a;
    sst <= 24'(p_sst >> QW); stt <= 24'(p_stt >> QW);
    ttt <= 24'(p_ttt >> QW); c1c <= c1b; c2c <= c2b;
    a <= 24'(p_a >> QW); b <= 24'(p_b >> QW); ttt2 <= ttt;
  end
  assign value = 26'(a) + 26'(b) + 26'(ttt2);
  assign done = vld[3];
endmodule

// ----- hdl/bezier_easing_table.sv -----
// Bezier easing table top level.
// Evaluate: two table reads through the single RAM read port (upper neighbor,
// then lower), then the interpolation; no new word is accepted until the
// result is taken. Rebuild: the edge entries, then per entry up to
// MAX_SOLVE_STEPS solver passes through the curve pipeline plus a pass for y
// and the write; the linear case skips the rebuild and goes to the result.
// Reset: registers 0, linear mode on, table contents undefined until rebuilt.
module bezier_easing_table #(
  parameter int TABLE_STEPS = bet_pkg::TABLE_STEPS_DEF,
  parameter int MAX_SOLVE_STEPS = bet_pkg::MAX_SOLVE_STEPS_DEF
) (
  input logic clk,
  input logic rst,
  bet_if.sink in_ch,
  bet_if.source out_ch,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [6:0] cfg_data
);
  import bet_pkg::*;
  localparam int AW = $clog2(TABLE_STEPS + 1);
  localparam int SB = $clog2(TABLE_STEPS);
  localparam int NW = $clog2(MAX_SOLVE_STEPS + 1);

  state_t state, state_next;
  logic [6:0] x1, y1, x2, y2;
  logic identity;
  logic [16:0] prog, res;
  logic [AW-1:0] idx, ridx, waddr;
  logic [15:0] frac;
  logic [16:0] ta, rdata, wdata;
  logic we;
  logic [33:0] m0, m1;
  logic [NW-1:0] n;
  logic [23:0] t, target;
  logic edge_phase;
  logic want_y;
  curve_req_t req;
  logic cdone;
  logic [25:0] cval;
  logic [25:0] err;
  logic ge, small_e;
  logic [23:0] mag;
  logic [24:0] tsum;
  logic [16+SB:0] pos;

  bet_ram #(.WIDTH(17), .DEPTH(TABLE_STEPS + 1)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ridx), .rdata(rdata));
  bet_curve u_curve (.clk(clk), .rst(rst), .req(req), .done(cdone), .value(cval));

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0; y1 <= '0; x2 <= '0; y2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X1: x1 <= cfg_data;
        REG_Y1: y1 <= cfg_data;
        REG_X2: x2 <= cfg_data;
        REG_Y2: y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos = (17'(in_ch.data[16:0]) > OUT_ONE ? (17+SB)'(OUT_ONE)
               : (17+SB)'(in_ch.data[16:0])) * (17+SB)'(TABLE_STEPS);
  assign ge = cval >= 26'(target);
  assign err = ge ? cval - 26'(target) : 26'(target) - cval;
  assign small_e = err < 26'(SOLVE_EPS);
  assign mag = 24'(err >> 1);
  assign tsum = 25'(t) + 25'(mag);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid) begin
        if (!in_ch.data[17]) state_next = ST_EV_RD;
        else if (x1 == y1 && x2 == y2) state_next = ST_OUT;
        else state_next = ST_RB_EDGE;
      end
      ST_EV_RD: state_next = ST_EV_WAIT;
      ST_EV_WAIT: state_next = ST_EV_MUL;
      ST_EV_MUL: state_next = ST_EV_SUM;
      ST_EV_SUM: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      ST_RB_EDGE: if (edge_phase) state_next = ST_RB_EVAL;
      ST_RB_EVAL: state_next = ST_RB_STEP;
      ST_RB_STEP: if (cdone) begin
        if (want_y) state_next = ST_RB_WR;
        else state_next = ST_RB_EVAL;
      end
      ST_RB_WR: state_next = (idx == AW'(TABLE_STEPS - 1)) ? ST_OUT : ST_RB_EVAL;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    out_ch.valid = (state == ST_OUT);
    out_ch.data = {identity, res};
    req.start = (state == ST_RB_EVAL);
    req.t = t;
    req.c1 = coef_of(want_y ? y1 : x1);
    req.c2 = coef_of(want_y ? y2 : x2);
    we = 1'b0; waddr = idx; wdata = '0;
    if (state == ST_RB_EDGE) begin
      we = 1'b1;
      waddr = edge_phase ? AW'(TABLE_STEPS) : '0;
      wdata = edge_phase ? OUT_ONE : '0;
    end else if (state == ST_RB_WR) begin
      we = 1'b1;
      wdata = 17'(((cval > 26'(Q_ONE) ? 26'(Q_ONE) : cval) + 26'd32) >> 6);
    end
  end

  // upper neighbor first (held in ta), lower one arrives on rdata for the sum
  assign ridx = (state == ST_EV_RD && idx != AW'(TABLE_STEPS)) ? AW'(idx + AW'(1)) : idx;
  assign m0 = 34'(ta) * 34'(frac);
  assign m1 = 34'(rdata) * 34'(18'(OUT_ONE) - 18'(frac));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; identity <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_ch.valid && in_ch.data[17])
        identity <= (x1 == y1 && x2 == y2);
    end
    case (state)
      ST_IDLE: begin
        edge_phase <= 1'b0; want_y <= 1'b0;
        res <= '0;
        frac <= (pos[16+SB:16] >= (SB+1)'(TABLE_STEPS)) ? 16'd0 : pos[15:0];
        prog <= in_ch.data[16:0] > OUT_ONE ? OUT_ONE : in_ch.data[16:0];
        if (in_ch.data[17]) begin
          idx <= AW'(1);
          target <= 24'((32'(1) << QW) / 32'(TABLE_STEPS));
          t <= 24'((32'(1) << QW) / 32'(TABLE_STEPS));
          n <= '0;
        end else begin
          idx <= (pos[16+SB:16] >= (SB+1)'(TABLE_STEPS)) ? AW'(TABLE_STEPS)
                 : AW'(pos[16+SB:16]);
        end
      end
      ST_EV_WAIT: ta <= rdata;
      ST_EV_SUM: begin
        if (identity) res <= prog;
        else if (idx == AW'(TABLE_STEPS)) res <= ta;
        else res <= 17'((35'(m0) + 35'(m1) + 35'd32768) >> 16);
      end
      ST_RB_EDGE: edge_phase <= 1'b1;
      ST_RB_STEP: if (cdone && !want_y) begin
        if (small_e || n == NW'(MAX_SOLVE_STEPS - 1)) want_y <= 1'b1;
        if (!small_e) begin
          if (ge) t <= (mag > t) ? '0 : t - mag;
          else t <= (tsum > 25'(Q_ONE)) ? Q_ONE : 24'(tsum);
        end
        n <= NW'(n + NW'(1));
      end
      ST_RB_WR: begin
        want_y <= 1'b0; n <= '0;
        idx <= AW'(idx + AW'(1));
        target <= 24'((32'(idx + AW'(1)) << QW) / 32'(TABLE_STEPS));
        t <= 24'((32'(idx + AW'(1)) << QW) / 32'(TABLE_STEPS));
      end
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("result changed under stall");
  a_lin: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && identity |-> out_ch.data[16:0] <= OUT_ONE)
    else $error("eased above one");
endmodule
